FILE: sv/cthc_pkg.sv
// ----------------------------------------------------------------------------
// cthc_pkg
// Shared constants, types and the arctangent table of the compass heading unit.
// ----------------------------------------------------------------------------
package cthc_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int STEPS        = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
	localparam int CNT_W        = $clog2(STEPS + 1);

	localparam int XY_W   = 52;
	localparam int Z_W    = 34;
	localparam int MUL_W  = 34;
	localparam int PROD_W = 2 * MUL_W;

	localparam logic signed [Z_W-1:0]  QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [Z_W-1:0]  HALF_TURN    = 34'sd2147483648;
	localparam logic signed [XY_W-1:0] INV_GAIN_Q30 = 52'sd652032874;
	localparam logic signed [MUL_W-1:0] FULL_CIRCLE = 34'sd46080;
	localparam logic signed [17:0]     HALF_CIRCLE  = 18'sd23040;
	localparam logic signed [17:0]     FULL_CIRC18  = 18'sd46080;

	typedef struct packed {
		logic load;
		logic vec;
	} cthc_cordic_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROTP,
		ST_ROTR,
		ST_MUL,
		ST_VLOAD,
		ST_VEC,
		ST_SCALE,
		ST_ROUND
	} cthc_state_t;

	function automatic logic signed [Z_W-1:0] atan_lut(input logic [CNT_W-1:0] i);
		logic signed [Z_W-1:0] r;
		unique case (5'(i))
			5'd0:  r = 34'sd536870912;
			5'd1:  r = 34'sd316933406;
			5'd2:  r = 34'sd167458907;
			5'd3:  r = 34'sd85004756;
			5'd4:  r = 34'sd42667331;
			5'd5:  r = 34'sd21354465;
			5'd6:  r = 34'sd10679838;
			5'd7:  r = 34'sd5340245;
			5'd8:  r = 34'sd2670163;
			5'd9:  r = 34'sd1335087;
			5'd10: r = 34'sd667544;
			5'd11: r = 34'sd333772;
			5'd12: r = 34'sd166886;
			5'd13: r = 34'sd83443;
			5'd14: r = 34'sd41722;
			5'd15: r = 34'sd20861;
			5'd16: r = 34'sd10430;
			5'd17: r = 34'sd5215;
			5'd18: r = 34'sd2608;
			5'd19: r = 34'sd1304;
			5'd20: r = 34'sd652;
			5'd21: r = 34'sd326;
			5'd22: r = 34'sd163;
			5'd23: r = 34'sd81;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/cthc_mul.sv
// ----------------------------------------------------------------------------
// cthc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module cthc_mul import cthc_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  a,
	input  logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0] prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

endmodule

FILE: sv/cthc_cordic.sv
// ----------------------------------------------------------------------------
// cthc_cordic
// Shared CORDIC stage, one micro-rotation per cycle, rotation or vectoring.
// ----------------------------------------------------------------------------
module cthc_cordic import cthc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cthc_cordic_ctl_t        ctl,
	input  logic signed [XY_W-1:0]  x_in,
	input  logic signed [XY_W-1:0]  y_in,
	input  logic signed [Z_W-1:0]   z_in,
	output logic signed [XY_W-1:0]  x_q,
	output logic signed [XY_W-1:0]  y_q,
	output logic signed [Z_W-1:0]   z_q,
	output logic                    done
);

	logic [CNT_W-1:0]       cnt_q;
	logic                   vec_q;
	logic                   ccw;
	logic signed [XY_W-1:0] xs, ys;
	logic signed [Z_W-1:0]  a;

	assign xs   = x_q >>> cnt_q;
	assign ys   = y_q >>> cnt_q;
	assign a    = atan_lut(cnt_q);
	assign ccw  = vec_q ? y_q[XY_W-1] : !z_q[Z_W-1];
	assign done = (cnt_q == CNT_W'(STEPS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_W'(STEPS);
			vec_q <= 1'b0;
		end else if (ctl.load) begin
			cnt_q <= '0;
			vec_q <= ctl.vec;
		end else if (cnt_q != CNT_W'(STEPS)) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= x_in;
			y_q <= y_in;
			z_q <= z_in;
		end else if (cnt_q != CNT_W'(STEPS)) begin
			if (ccw) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - a;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + a;
			end
		end
	end

endmodule

FILE: sv/tilt_compensated_compass_heading_unit.sv
// ----------------------------------------------------------------------------
// tilt_compensated_compass_heading_unit
// Tilt-compensated magnetometer heading in 1/128 degree.
// ----------------------------------------------------------------------------
// Each item makes two sin/cos passes, one for pitch and one for roll, through
// the single shared CORDIC stage, uses the shared multiplier for the tilt
// rotation, and then goes through load, one atan2 pass, scale and round.
// in_stall stays high while an item is at work; the result waits in an output
// register, so the next item may enter while it is still stalled.
// ----------------------------------------------------------------------------
module tilt_compensated_compass_heading_unit import cthc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic signed [15:0] cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               data_ready,
	input  logic signed [15:0] mag_x,
	input  logic signed [15:0] mag_y,
	input  logic signed [15:0] mag_z,
	input  logic signed [15:0] pitch_angle,
	input  logic signed [15:0] roll_angle,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [16:0] bearing,
	output logic        [15:0] heading
);

	cthc_state_t state_q, state_d;

	logic signed [15:0]     offset_q;
	logic signed [15:0]     last_x_q, last_y_q, last_z_q;
	logic signed [15:0]     roll_q;
	logic                   flip_q, flip_d;
	logic                   zero_q;
	logic [2:0]             mc_q;
	logic signed [MUL_W-1:0] cp_q, sp_q, cr_q, sr_q, spsr_q, spcr_q;
	logic signed [XY_W-1:0] acc_q, xh_q, yh_q;
	logic                   out_valid_q;
	logic signed [16:0]     bearing_q;
	logic [15:0]            heading_q;

	cthc_cordic_ctl_t       cctl;
	logic signed [XY_W-1:0] cx_in, cy_in, cx, cy, fx, fy;
	logic signed [Z_W-1:0]  cz_in, cz, zang;
	logic                   cdone;
	logic signed [15:0]     ang;

	logic signed [MUL_W-1:0]  ma, mb;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [XY_W-1:0]   prod52;
	logic signed [MUL_W-1:0]  prod_q30;

	logic signed [PROD_W-1:0] rnd;
	logic signed [17:0]       r_raw, r_clamp, b18, h18;
	logic                     accept, out_free;

	cthc_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cctl),
		.x_in   (cx_in),
		.y_in   (cy_in),
		.z_in   (cz_in),
		.x_q    (cx),
		.y_q    (cy),
		.z_q    (cz),
		.done   (cdone)
	);

	cthc_mul u_mul (
		.clk     (clk),
		.a       (ma),
		.b       (mb),
		.prod_s1 (prod_s1)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign bearing   = bearing_q;
	assign heading   = heading_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign prod52   = prod_s1[XY_W-1:0];
	assign prod_q30 = MUL_W'(prod_s1 >>> 30);
	assign fx       = flip_q ? -cx : cx;
	assign fy       = flip_q ? -cy : cy;

	// angle pre-fold for rotation mode
	assign ang  = (state_q == ST_IDLE) ? pitch_angle : roll_q;
	assign zang = {{2{ang[15]}}, ang, 16'b0};

	always_comb begin
		flip_d = 1'b0;
		cz_in  = zang;
		cx_in  = INV_GAIN_Q30;
		cy_in  = '0;
		cctl   = '{load: 1'b0, vec: 1'b0};
		if (zang > QUARTER_TURN) begin
			cz_in  = zang - HALF_TURN;
			flip_d = 1'b1;
		end else if (zang < -QUARTER_TURN) begin
			cz_in  = zang + HALF_TURN;
			flip_d = 1'b1;
		end
		if (state_q == ST_VLOAD) begin
			cctl.vec = 1'b1;
			if (!xh_q[XY_W-1]) begin
				cx_in = xh_q;
				cy_in = yh_q;
				cz_in = '0;
			end else if (!yh_q[XY_W-1]) begin
				cx_in = yh_q;
				cy_in = -xh_q;
				cz_in = QUARTER_TURN;
			end else begin
				cx_in = -yh_q;
				cy_in = xh_q;
				cz_in = -QUARTER_TURN;
			end
		end
		unique case (state_q)
			ST_IDLE:  cctl.load = accept;
			ST_ROTP:  cctl.load = cdone;
			ST_VLOAD: cctl.load = 1'b1;
			default:  cctl.load = 1'b0;
		endcase
	end

	always_comb begin
		ma = cz;
		mb = FULL_CIRCLE;
		if (state_q == ST_MUL) begin
			unique case (mc_q)
				3'd0: begin ma = sp_q;   mb = sr_q; end
				3'd1: begin ma = sp_q;   mb = cr_q; end
				3'd2: begin ma = cp_q;   mb = MUL_W'(last_x_q); end
				3'd3: begin ma = spsr_q; mb = MUL_W'(last_y_q); end
				3'd4: begin ma = spcr_q; mb = MUL_W'(last_z_q); end
				3'd5: begin ma = cr_q;   mb = MUL_W'(last_y_q); end
				3'd6: begin ma = sr_q;   mb = MUL_W'(last_z_q); end
				default: begin ma = '0;  mb = '0; end
			endcase
		end
	end

	assign rnd   = (prod_s1 + (PROD_W'(1) <<< 31)) >>> 32;
	assign r_raw = 18'(rnd);
	always_comb begin
		priority if (zero_q)
			r_clamp = '0;
		else if (r_raw > HALF_CIRCLE)
			r_clamp = HALF_CIRCLE;
		else if (r_raw < -HALF_CIRCLE)
			r_clamp = -HALF_CIRCLE;
		else
			r_clamp = r_raw;
		b18 = r_clamp - 18'(offset_q);
		h18 = (b18 > 18'sd0) ? b18 : FULL_CIRC18 + b18;
		if (h18 < 18'sd0)
			h18 = '0;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = ST_ROTP;
			ST_ROTP:  if (cdone) state_d = ST_ROTR;
			ST_ROTR:  if (cdone) state_d = ST_MUL;
			ST_MUL:   if (mc_q == 3'd7) state_d = ST_VLOAD;
			ST_VLOAD: state_d = ST_VEC;
			ST_VEC:   if (cdone) state_d = ST_SCALE;
			ST_SCALE: state_d = ST_ROUND;
			ST_ROUND: if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			offset_q    <= '0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			last_z_q    <= '0;
			out_valid_q <= 1'b0;
			mc_q        <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready)
				offset_q <= cfg_data;
			if (accept && data_ready) begin
				last_x_q <= mag_x;
				last_y_q <= mag_y;
				last_z_q <= mag_z;
			end
			if (state_q == ST_MUL)
				mc_q <= mc_q + 1'b1;
			else
				mc_q <= '0;
			if (state_q == ST_ROUND && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			roll_q <= roll_angle;
		if (cctl.load && !cctl.vec)
			flip_q <= flip_d;
		if (state_q == ST_ROTP && cdone) begin
			cp_q <= MUL_W'(fx);
			sp_q <= MUL_W'(fy);
		end
		if (state_q == ST_ROTR && cdone) begin
			cr_q <= MUL_W'(fx);
			sr_q <= MUL_W'(fy);
		end
		if (state_q == ST_MUL) begin
			unique case (mc_q)
				3'd1:    spsr_q <= prod_q30;
				3'd2:    spcr_q <= prod_q30;
				3'd3:    acc_q  <= prod52;
				3'd4:    acc_q  <= acc_q + prod52;
				3'd5:    xh_q   <= acc_q + prod52;
				3'd6:    acc_q  <= prod52;
				3'd7:    yh_q   <= acc_q + prod52;
				default: acc_q  <= acc_q;
			endcase
		end
		if (state_q == ST_VLOAD)
			zero_q <= (xh_q == '0) && (yh_q == '0);
		if (state_q == ST_ROUND && out_free) begin
			bearing_q <= 17'(b18);
			heading_q <= 16'(h18);
		end
	end

endmodule
